// ===== rtl/rtfp_pkg.sv =====
// Shared constants, types and helpers for the radar target frame parser.
`timescale 1ns / 1ps

package rtfp_pkg;

	// Sizing of the frame store and the report.
	localparam int FRAME_BYTES = 64;
	localparam int MAX_TARGETS = 5;

	localparam int CNT_W  = $clog2(FRAME_BYTES + 1);
	localparam int ADDR_W = $clog2(FRAME_BYTES);
	localparam int TGT_W  = $clog2(MAX_TARGETS + 1);

	// Frame layout: header 0..3, function byte 4, length 5..6, payload from 7.
	localparam int FUNC_POS    = 4;
	localparam int LEN_HI_POS  = 6;
	localparam int PAYLOAD_POS = 7;
	localparam int MIN_FRAME   = 15;
	localparam int OVERHEAD    = 11;
	localparam int TAIL_BYTES  = 4;

	// Register reset values.
	localparam logic [31:0] HEADER_RESET = 32'hF1F2_F3F4;
	localparam logic [31:0] TAIL_RESET   = 32'hF5F6_F7F8;
	localparam logic [7:0]  CODE_RESET   = 8'd4;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_HEADER = 2'd0,
		REG_TAIL   = 2'd1,
		REG_CODE   = 2'd2
	} reg_idx_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic             accept_en;
		logic             rd_en;
		logic [1:0]       sub;
		logic [TGT_W-1:0] tgt;
		logic             load;
		logic             last;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic             frame_good;
		logic [TGT_W-1:0] n_tgt;
		logic             out_free;
	} stat_t;

	// Byte k of a four-byte pattern, first byte in the lowest bits.
	function automatic logic [7:0] pat_byte(input logic [31:0] pat, input logic [1:0] k);
		logic [31:0] sh;
		sh = pat >> {k, 3'b000};
		return sh[7:0];
	endfunction

endpackage

// ===== rtl/rtfp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module rtfp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/rtfp_ctrl.sv =====
// Controller state machine that sequences target readout after a good frame.
`timescale 1ns / 1ps

module rtfp_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  rtfp_pkg::stat_t stat,
	output rtfp_pkg::cmd_t  cmd
);
	import rtfp_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_FETCH = 4'b0010,
		S_DRAIN = 4'b0100,
		S_EMIT  = 4'b1000
	} state_t;

	state_t           state_q;
	logic [TGT_W-1:0] tgt_q;
	logic [1:0]       sub_q;
	logic             last;

	// The current target is the final one of the report.
	assign last = ({1'b0, tgt_q} + (TGT_W + 1)'(1)) == {1'b0, stat.n_tgt};

	// State, target counter and byte-within-target counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			tgt_q   <= '0;
			sub_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (stat.frame_good) begin
						state_q <= S_FETCH;
						tgt_q   <= '0;
						sub_q   <= '0;
					end
				end
				S_FETCH: begin
					sub_q <= sub_q + 2'd1;
					if (sub_q == 2'd3) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (stat.out_free) begin
						if (last) begin
							state_q <= S_IDLE;
						end else begin
							state_q <= S_FETCH;
							tgt_q   <= tgt_q + TGT_W'(1);
							sub_q   <= '0;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Commands to the datapath.
	always_comb begin
		cmd.accept_en = (state_q == S_IDLE) && !stat.frame_good;
		cmd.rd_en     = (state_q == S_FETCH);
		cmd.sub       = sub_q;
		cmd.tgt       = tgt_q;
		cmd.load      = (state_q == S_EMIT) && stat.out_free;
		cmd.last      = last;
	end

`ifndef SYNTH
	// A completed frame is only reported while no readout is running.
	a_good_in_idle: assert property (@(posedge clk) disable iff (!arst_n)
		stat.frame_good |-> (state_q == S_IDLE))
		else $error("frame completion seen outside idle");

	// Readout never addresses a target beyond the reported count.
	a_tgt_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FETCH) |-> (tgt_q < stat.n_tgt))
		else $error("target index beyond count during fetch");

	// Loading the final result returns the controller to idle.
	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load && cmd.last |=> (state_q == S_IDLE))
		else $error("controller did not return to idle after last result");
`endif

endmodule

// ===== rtl/rtfp_dp.sv =====
// Datapath: byte parser, frame store, target assembly and output register.
`timescale 1ns / 1ps

module rtfp_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [7:0]      in_byte,
	input  logic            cfg_valid,
	input  logic [1:0]      cfg_index,
	input  logic [31:0]     cfg_data,
	input  logic            out_ready,
	output logic            out_valid,
	output logic [15:0]     x_pos,
	output logic [15:0]     y_pos,
	output logic [2:0]      target_index,
	output logic [2:0]      target_count,
	output logic            last,
	input  rtfp_pkg::cmd_t  cmd,
	output rtfp_pkg::stat_t stat
);
	import rtfp_pkg::*;

	localparam int RA_W = ADDR_W + TGT_W + 3;

	// Configuration registers.
	logic [31:0] header_q;
	logic [31:0] tail_q;
	logic [7:0]  code_q;

	// Parser state.
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [CNT_W-1:0] fl_q, fl_d;
	logic             tail_ok_q, tail_ok_d;
	logic [7:0]       func_q;
	logic [7:0]       len_lo_q;
	logic             frame_good_q, frame_good_d;
	logic [TGT_W-1:0] n_q;

	// Readout.
	logic        rd_pend_s1;
	logic [31:0] asm_q;
	logic [7:0]  rdata;

	// Output register.
	logic        out_valid_q;

	logic             in_fire;
	logic             full;
	logic [CNT_W-1:0] eff_cnt;
	logic [CNT_W-1:0] eff_fl;
	logic [CNT_W-1:0] new_cnt;
	logic             hunt_drop;
	logic             we;
	logic [15:0]      len_val;
	logic [16:0]      len_ext;
	logic [CNT_W-1:0] tail_off;
	logic             tail_win;
	logic             tail_hit;
	logic             payload_ok;
	logic [CNT_W-1:0] quads;
	logic [CNT_W-1:0] n_sat;
	logic [RA_W-1:0]  raddr_full;

	assign in_fire = in_valid && cmd.accept_en;

	// A full store restarts the hunt before the byte is looked at.
	assign full    = cnt_q >= CNT_W'(FRAME_BYTES);
	assign eff_cnt = full ? '0 : cnt_q;
	assign eff_fl  = full ? '0 : fl_q;
	assign new_cnt = eff_cnt + CNT_W'(1);

	assign hunt_drop = (eff_cnt == '0) && (in_byte != pat_byte(header_q, 2'd0));
	assign we        = in_fire && !hunt_drop;

	// Length field and its two readings.
	assign len_val = {in_byte, len_lo_q};
	assign len_ext = {1'b0, len_val} + 17'(OVERHEAD);

	// Tail window covers the last four bytes of the frame.
	assign tail_off = eff_cnt - eff_fl;
	assign tail_win = (eff_fl != '0) &&
		(({1'b0, eff_cnt} + (CNT_W + 1)'(TAIL_BYTES)) >= {1'b0, eff_fl});
	assign tail_hit = in_byte == pat_byte(tail_q, tail_off[1:0]);

	// Payload is total minus 11, so a multiple of four means total mod 4 is 3.
	assign payload_ok = (eff_fl[1:0] == 2'b11);

	// Number of targets, saturated to the maximum.
	assign quads = (eff_fl - CNT_W'(OVERHEAD)) >> 2;
	assign n_sat = (quads > CNT_W'(MAX_TARGETS)) ? CNT_W'(MAX_TARGETS) : quads;

	// Next parser state for an accepted byte.
	always_comb begin
		cnt_d        = cnt_q;
		fl_d         = fl_q;
		tail_ok_d    = tail_ok_q;
		frame_good_d = 1'b0;
		if (in_fire) begin
			priority if (hunt_drop) begin
				cnt_d = '0;
				fl_d  = '0;
			end else if ((eff_cnt >= CNT_W'(1)) && (eff_cnt <= CNT_W'(3)) &&
				(in_byte != pat_byte(header_q, eff_cnt[1:0]))) begin
				cnt_d = '0;
				fl_d  = '0;
			end else if (eff_cnt == CNT_W'(LEN_HI_POS)) begin
				cnt_d = new_cnt;
				fl_d  = eff_fl;
				priority if (func_q != code_q) begin
					cnt_d = '0;
					fl_d  = '0;
				end else if ((len_val >= 16'(MIN_FRAME)) &&
					(len_val <= 16'(FRAME_BYTES))) begin
					fl_d = CNT_W'(len_val);
				end else if ((len_ext >= 17'(MIN_FRAME)) &&
					(len_ext <= 17'(FRAME_BYTES))) begin
					fl_d = CNT_W'(len_ext);
				end else begin
					cnt_d = '0;
					fl_d  = '0;
				end
			end else if ((eff_fl != '0) && (new_cnt == eff_fl)) begin
				// Final byte: check tail and payload size, then restart.
				frame_good_d = tail_ok_q && tail_hit && payload_ok;
				cnt_d        = '0;
				fl_d         = '0;
			end else begin
				cnt_d = new_cnt;
				fl_d  = eff_fl;
				if (eff_cnt == '0) begin
					tail_ok_d = 1'b1;
				end else if (tail_win && !tail_hit) begin
					tail_ok_d = 1'b0;
				end
			end
		end
	end

	// Parser control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			fl_q         <= '0;
			tail_ok_q    <= 1'b1;
			frame_good_q <= 1'b0;
		end else begin
			cnt_q        <= cnt_d;
			fl_q         <= fl_d;
			tail_ok_q    <= tail_ok_d;
			frame_good_q <= frame_good_d;
		end
	end

	// Function byte, low length byte and target count.
	always_ff @(posedge clk) begin
		if (we && (eff_cnt == CNT_W'(FUNC_POS))) begin
			func_q <= in_byte;
		end
		if (we && (eff_cnt == CNT_W'(FUNC_POS + 1))) begin
			len_lo_q <= in_byte;
		end
		if (frame_good_d) begin
			n_q <= TGT_W'(n_sat);
		end
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= HEADER_RESET;
			tail_q   <= TAIL_RESET;
			code_q   <= CODE_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_HEADER: header_q <= cfg_data;
				REG_TAIL:   tail_q   <= cfg_data;
				REG_CODE:   code_q   <= cfg_data[7:0];
				default:    ;
			endcase
		end
	end

	// Frame store.
	assign raddr_full = RA_W'(PAYLOAD_POS) + RA_W'({cmd.tgt, 2'b00}) + RA_W'(cmd.sub);

	rtfp_ram #(
		.WIDTH(8),
		.DEPTH(FRAME_BYTES)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(eff_cnt[ADDR_W-1:0]),
		.wdata(in_byte),
		.re   (cmd.rd_en),
		.raddr(raddr_full[ADDR_W-1:0]),
		.rdata(rdata)
	);

	// Assemble the four target bytes, first byte ending in the lowest bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_pend_s1 <= 1'b0;
		end else begin
			rd_pend_s1 <= cmd.rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_pend_s1) begin
			asm_q <= {rdata, asm_q[31:8]};
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_pos        <= asm_q[15:0];
			y_pos        <= asm_q[31:16];
			target_index <= 3'(cmd.tgt);
			target_count <= 3'(n_q);
			last         <= cmd.last;
		end
	end

	assign out_valid       = out_valid_q;
	assign stat.frame_good = frame_good_q;
	assign stat.n_tgt      = n_q;
	assign stat.out_free   = !out_valid_q || out_ready;

`ifndef SYNTH
	// A good frame always carries at least one target.
	a_nonzero_count: assert property (@(posedge clk) disable iff (!arst_n)
		frame_good_q |-> (n_q != '0))
		else $error("good frame with zero targets");
`endif

endmodule

// ===== rtl/radar_target_frame_parser.sv =====
// Top level of the radar target frame parser.
//
//  channel   direction  handshake                       payload
//  s_axis    in         s_axis_tvalid / s_axis_tready   byte_in
//  m_axis    out        m_axis_tvalid / m_axis_tready   x, y, index, count, tlast=last
//  cfg       in         cfg_valid / cfg_ready           cfg_index, cfg_data
//
// Each received byte takes one cycle. After the final byte of a good frame,
// every target is read from the frame store four bytes through its one read
// port, each target waiting for a free output register; no bytes are
// taken during that readout. Reset clears the parser and loads the default
// patterns; the frame store needs no clearing. The output register lets the
// parser take the next byte while the final result still waits.
`timescale 1ns / 1ps

module radar_target_frame_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] byte_in
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // [15:0] x_pos, [31:16] y_pos,
	                                   // [34:32] target_index, [37:35] target_count
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import rtfp_pkg::*;

	cmd_t        cmd;
	stat_t       stat;
	logic [15:0] x_pos;
	logic [15:0] y_pos;
	logic [2:0]  target_index;
	logic [2:0]  target_count;

	rtfp_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.stat  (stat),
		.cmd   (cmd)
	);

	rtfp_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_byte     (s_axis_tdata),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.out_ready   (m_axis_tready),
		.out_valid   (m_axis_tvalid),
		.x_pos       (x_pos),
		.y_pos       (y_pos),
		.target_index(target_index),
		.target_count(target_count),
		.last        (m_axis_tlast),
		.cmd         (cmd),
		.stat        (stat)
	);

	// Handshakes and result packing.
	assign s_axis_tready = cmd.accept_en;
	assign cfg_ready     = 1'b1;
	assign m_axis_tdata  = {2'b00, target_count, target_index, y_pos, x_pos};

endmodule
